// File: rtl/mfe_pkg.sv
// package for the metaball field evaluator
// shared payload types, action codes and sizing constants; no dependencies
package mfe_pkg;

  localparam int MAX_BALLS_DEF = 16;

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_ADD   = 2'd1,
    ACT_EVAL  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic [15:0]        radius;
  } mfe_in_t;

  typedef struct packed {
    logic [31:0]        field_value;
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] normal_z;
    logic               status;
    logic [4:0]         stored_balls;
  } mfe_out_t;

endpackage

// File: rtl/mfe_ram.sv
// generic single-port-write ram with registered read
// no dependencies
module mfe_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/metaball_field_evaluator_top.sv
// metaball field evaluator top level
// depends on mfe_pkg and mfe_ram
//
// Clear, add and unused-code items, and evaluations with no stored balls,
// go from the accept straight to the output state, which hands the result
// to the output register. An evaluation walks the stored balls one at a
// time. For each ball it reads the entry, forms the differences, squares
// them and runs four divisions through one shared restoring divider, one
// quotient bit per cycle. The first is a 48-bit value quotient, and three
// capped normal quotients follow, each over a 72-bit numerator. After each
// division's last bit a further step folds in its quotient and loads the
// next numerator. One shared 17 by 48 multiplier forms the squares and the
// normal numerators. After the divisions a step moves on to the next ball or
// to the output. The block takes no new item while one is in progress. A
// finished result waits in an output register, so a stalled receiver holds
// back only the next result and not the next item. Ball storage is four
// small rams, read one entry per ball. Only entries below the ball count are
// read, so there is no clearing pass.
module metaball_field_evaluator_top #(
  parameter int MAX_BALLS = mfe_pkg::MAX_BALLS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  mfe_pkg::mfe_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output mfe_pkg::mfe_out_t out_data
);
  import mfe_pkg::*;

  localparam int AW = (MAX_BALLS > 1) ? $clog2(MAX_BALLS) : 1;
  localparam int CW = $clog2(MAX_BALLS + 1);
  localparam int NUMW = 72;     // widest numerator, |d| * q * 2^8
  localparam int QW = 48;       // value quotient width
  localparam int DW = 35;       // divisor width
  localparam int FW = QW + CW;  // field sum width
  localparam int NW = 42 + CW;  // normal sum width
  localparam logic [40:0] CAP = 41'h100_0000_0000;
  localparam logic [6:0] VAL_BITS = 7'd48;
  localparam logic [6:0] NRM_BITS = 7'd72;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_READ  = 7'b0000010,
    S_DIFF  = 7'b0000100,
    S_SQ    = 7'b0001000,
    S_DIV   = 7'b0010000,
    S_ACC   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  mfe_in_t  item_r;
  mfe_out_t res_r;
  mfe_out_t out_r;
  logic     outv_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] k_r;

  // per-ball registers
  logic signed [16:0] d_r [3];
  logic [DW-1:0]   s_r;
  logic [1:0]      sq_r;        // axis being squared
  logic [1:0]      job_r;       // 0 value, 1..3 normals
  logic [QW-1:0]   q_r;         // value quotient
  logic [NUMW-1:0] num_r;
  logic [DW:0]     rem_r;
  logic [QW-1:0]   quo_r;
  logic [6:0]      bit_r;
  logic            capd_r;
  logic [FW-1:0]   field_r;
  logic signed [NW-1:0] nacc_r [3];

  // ball storage signals
  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [15:0] cx, cy, cz;
  logic [31:0] r2;
  logic room;

  logic accept;
  logic out_load;
  logic [CW-1:0] count_nxt;
  mfe_out_t idle_res;
  mfe_out_t fin_res;

  // shared multiplier and divider signals
  logic [1:0]    mul_ax;
  logic [16:0]   mul_a;
  logic [QW-1:0] mul_b;
  logic [64:0]   prod;
  logic [DW:0]   rem_sh;
  logic          take;
  logic [6:0]    nbits;
  logic [DW-1:0] s_sum;
  logic [40:0]   term;
  logic [1:0]    nax;

  function automatic logic [16:0] abs17(input logic signed [16:0] v);
    return v[16] ? 17'(-v) : 17'(v);
  endfunction

  function automatic logic [31:0] sat32(input logic signed [NW-1:0] v);
    logic [NW-32:0] top;
    top = v[NW-1:31];
    if (!(|top) || (&top)) return v[31:0];
    return v[NW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
  endfunction

  // ball storage
  assign room  = count_r < CW'(MAX_BALLS);
  assign waddr = AW'(count_r);
  assign raddr = AW'(k_r);
  mfe_ram #(.WIDTH(16), .DEPTH(1 << AW)) u_cx (.clk, .we, .waddr, .wdata(in_data.pos_x),
    .raddr, .rdata(cx));
  mfe_ram #(.WIDTH(16), .DEPTH(1 << AW)) u_cy (.clk, .we, .waddr, .wdata(in_data.pos_y),
    .raddr, .rdata(cy));
  mfe_ram #(.WIDTH(16), .DEPTH(1 << AW)) u_cz (.clk, .we, .waddr, .wdata(in_data.pos_z),
    .raddr, .rdata(cz));
  mfe_ram #(.WIDTH(32), .DEPTH(1 << AW)) u_r2 (.clk, .we, .waddr,
    .wdata(32'(in_data.radius) * 32'(in_data.radius)), .raddr, .rdata(r2));

  // handshakes
  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign we        = accept && (in_data.action == ACT_ADD) && room;
  assign out_valid = outv_r;
  assign out_data  = out_r;
  assign out_load  = (state_r == S_OUT) && (!outv_r || out_ready);

  // ball count after the accepted item
  always_comb begin
    count_nxt = count_r;
    unique case (in_data.action)
      ACT_CLEAR: count_nxt = '0;
      ACT_ADD:   if (room) count_nxt = count_r + CW'(1);
      default: ;
    endcase
  end

  // result of an item that needs no walk
  always_comb begin
    idle_res = '0;
    idle_res.status = (in_data.action == ACT_ADD) && !room;
    idle_res.stored_balls = 5'(count_nxt);
  end

  // final saturation of an evaluation
  always_comb begin
    fin_res = '0;
    fin_res.field_value = (|field_r[FW-1:32]) ? 32'hFFFF_FFFF : field_r[31:0];
    fin_res.normal_x = sat32(nacc_r[0]);
    fin_res.normal_y = sat32(nacc_r[1]);
    fin_res.normal_z = sat32(nacc_r[2]);
    fin_res.stored_balls = 5'(count_r);
  end

  // shared multiplier: squares or |d| * q
  assign mul_ax = (state_r == S_SQ) ? sq_r : ((job_r == 2'd3) ? 2'd0 : job_r);
  assign mul_a  = abs17(d_r[mul_ax]);
  assign mul_b  = (state_r == S_SQ) ? QW'(mul_a) : ((job_r == 2'd0) ? quo_r : q_r);
  assign prod   = 65'(mul_a) * 65'(mul_b);
  assign s_sum  = s_r + DW'(prod);

  // shared divider step
  assign rem_sh = {rem_r[DW-1:0], num_r[NUMW-1]};
  assign take   = rem_sh >= {1'b0, s_r};
  assign nbits  = (job_r == 2'd0) ? VAL_BITS : NRM_BITS;
  assign term   = (capd_r || quo_r[40:0] > CAP) ? CAP : quo_r[40:0];
  assign nax    = job_r - 2'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        item_r  <= in_data;
        count_r <= count_nxt;
        res_r   <= idle_res;
        field_r <= '0;
        for (int a = 0; a < 3; a++) nacc_r[a] <= '0;
        k_r <= '0;
      end
      unique case (state_r)
        S_IDLE: ;
        S_READ: ;
        // differences per axis
        S_DIFF: begin
          d_r[0] <= 17'(item_r.pos_x) - 17'($signed(cx));
          d_r[1] <= 17'(item_r.pos_y) - 17'($signed(cy));
          d_r[2] <= 17'(item_r.pos_z) - 17'($signed(cz));
          s_r  <= '0;
          sq_r <= '0;
        end
        // squared distance, one axis a cycle
        S_SQ: begin
          sq_r <= sq_r + 2'd1;
          if (sq_r == 2'd2) begin
            s_r    <= (s_sum == '0) ? DW'(1) : s_sum;
            job_r  <= '0;
            bit_r  <= '0;
            rem_r  <= '0;
            quo_r  <= '0;
            capd_r <= 1'b0;
            num_r  <= {r2, 40'd0};
          end else begin
            s_r <= s_sum;
          end
        end
        // one quotient bit a cycle
        S_DIV: begin
          if (bit_r == nbits) begin
            if (job_r == 2'd0) begin
              q_r     <= quo_r;
              field_r <= field_r + FW'(quo_r);
            end else begin
              nacc_r[nax] <= d_r[nax][16] ? nacc_r[nax] - NW'(term)
                                          : nacc_r[nax] + NW'(term);
            end
            job_r  <= job_r + 2'd1;
            bit_r  <= '0;
            rem_r  <= '0;
            quo_r  <= '0;
            capd_r <= 1'b0;
            num_r  <= {prod[63:0], 8'd0};
          end else begin
            bit_r <= bit_r + 7'd1;
            num_r <= num_r << 1;
            rem_r <= take ? rem_sh - {1'b0, s_r} : rem_sh;
            quo_r <= {quo_r[QW-2:0], take};
            if (job_r != 2'd0 && quo_r[40]) capd_r <= 1'b1;
          end
        end
        // next ball or finish
        S_ACC: begin
          k_r <= k_r + CW'(1);
          if (k_r + CW'(1) == count_r) res_r <= fin_res;
        end
        S_OUT: ;
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outv_r <= 1'b0;
    end else if (out_load) begin
      outv_r <= 1'b1;
      out_r  <= res_r;
    end else if (out_ready) begin
      outv_r <= 1'b0;
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (accept)
                state_nxt = (in_data.action == ACT_EVAL && count_r != '0) ? S_READ : S_OUT;
      S_READ: state_nxt = S_DIFF;
      S_DIFF: state_nxt = S_SQ;
      S_SQ:   if (sq_r == 2'd2) state_nxt = S_DIV;
      S_DIV:  if (bit_r == nbits && job_r == 2'd3) state_nxt = S_ACC;
      S_ACC:  state_nxt = (k_r + CW'(1) == count_r) ? S_OUT : S_READ;
      S_OUT:  if (!outv_r || out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // checks
  a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r)) else $error("state not one-hot");
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_BALLS)) else $error("ball count overflow");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("result changed");
  a_walk: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_READ |-> k_r < count_r) else $error("ball index past count");
endmodule

// File: test/tb_metaball_field_evaluator_top.sv
// testbench for metaball_field_evaluator_top: clear, add, vertex evaluation and unused-code items
// depends on mfe_pkg and the block's rtl; predicts each result and checks it in order
module tb_metaball_field_evaluator_top;
  import mfe_pkg::*;

  localparam int NBALLS = MAX_BALLS_DEF;
  localparam longint CYCLE_LIMIT = 64'd20000000;
  localparam int TAIL_CYCLES = 6000;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  mfe_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  mfe_out_t out_data;

  // predictor copy of the ball table
  logic signed [15:0] tbl_x [NBALLS];
  logic signed [15:0] tbl_y [NBALLS];
  logic signed [15:0] tbl_z [NBALLS];
  logic [31:0]        tbl_r2 [NBALLS];
  int                 tbl_count;

  mfe_in_t  pending_items [$];
  mfe_out_t expected_results [$];
  int       mismatch_count;
  longint   cycle_count;
  int       in_idle;
  int       out_idle;
  bit       idling_on;
  bit       in_ready_seen;

  metaball_field_evaluator_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // floor(a * b * 256 / den) with the magnitude capped at 2^40
  function automatic logic [63:0] normal_term(logic [63:0] a, logic [63:0] b, logic [63:0] den);
    logic [135:0] num;
    logic [135:0] quo;
    num = ({72'd0, a} * {72'd0, b}) << 8;
    quo = num / {72'd0, den};
    if (quo > (136'd1 << 40)) return 64'd1 << 40;
    return quo[63:0];
  endfunction

  function automatic logic [31:0] sat32(longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  // apply one item to the table and compute its result
  function automatic mfe_out_t field_predict(mfe_in_t it);
    mfe_out_t res;
    logic [63:0] field;
    longint nrm [3];
    longint d [3];
    logic [63:0] s;
    logic [63:0] q;
    logic [63:0] mag;
    logic [63:0] t;
    res = '0;
    field = 0;
    nrm = '{0, 0, 0};
    case (it.action)
      ACT_CLEAR: tbl_count = 0;
      ACT_ADD: begin
        if (tbl_count < NBALLS) begin
          tbl_x[tbl_count] = it.pos_x;
          tbl_y[tbl_count] = it.pos_y;
          tbl_z[tbl_count] = it.pos_z;
          tbl_r2[tbl_count] = 32'(it.radius) * 32'(it.radius);
          tbl_count++;
        end else begin
          res.status = 1'b1;
        end
      end
      ACT_EVAL: begin
        for (int k = 0; k < tbl_count; k++) begin
          d[0] = longint'(it.pos_x) - longint'(tbl_x[k]);
          d[1] = longint'(it.pos_y) - longint'(tbl_y[k]);
          d[2] = longint'(it.pos_z) - longint'(tbl_z[k]);
          s = d[0] * d[0] + d[1] * d[1] + d[2] * d[2];
          if (s == 0) s = 1;
          q = ({32'd0, tbl_r2[k]} << 16) / s;
          field += q;
          for (int a = 0; a < 3; a++) begin
            mag = (d[a] < 0) ? -d[a] : d[a];
            t = normal_term(mag, q, s);
            nrm[a] += (d[a] < 0) ? -longint'(t) : longint'(t);
          end
        end
      end
      default: ;
    endcase
    res.field_value = (field > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : field[31:0];
    res.normal_x = sat32(nrm[0]);
    res.normal_y = sat32(nrm[1]);
    res.normal_z = sat32(nrm[2]);
    res.stored_balls = tbl_count[4:0];
    return res;
  endfunction

  function automatic mfe_in_t make_item(action_t act, int x, int y, int z, int r);
    mfe_in_t it;
    it.action = act;
    it.pos_x = x[15:0];
    it.pos_y = y[15:0];
    it.pos_z = z[15:0];
    it.radius = r[15:0];
    return it;
  endfunction

  // coordinate near a small cluster, sometimes anywhere
  function automatic int rand_coord();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 65535);
    return $urandom_range(0, 2047) - 1024;
  endfunction

  task automatic report_mismatch(string field_name, logic [63:0] got, logic [63:0] want);
    $display("error: %s got %0h expected %0h", field_name, got, want);
    mismatch_count++;
  endtask

  // driver: pops pending items, changes inputs on the falling edge
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready_seen) begin
        if (pending_items.size() > 0 && in_idle == 0 &&
            !(idling_on && $urandom_range(0, 15) == 0)) begin
          in_data <= pending_items.pop_front();
        end else begin
          in_valid <= 1'b0;
          if (idling_on && in_idle == 0) in_idle = $urandom_range(1, 16);
        end
      end else if (!in_valid) begin
        if (in_idle > 0) begin
          in_idle--;
        end else if (pending_items.size() > 0) begin
          if (idling_on && $urandom_range(0, 15) == 0) begin
            in_idle = $urandom_range(1, 16);
          end else begin
            in_valid <= 1'b1;
            in_data <= pending_items.pop_front();
          end
        end
      end
      // receiver stalls
      if (out_idle > 0) begin
        out_idle--;
        out_ready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 15) == 0) begin
        out_idle = $urandom_range(1, 16);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // accept tracking and monitor at the rising edge
  always @(posedge clk) begin
    mfe_out_t want;
    in_ready_seen <= rst_n && in_valid && in_ready;
    if (rst_n) begin
      cycle_count++;
      if (in_valid && in_ready) begin
        expected_results.push_back(field_predict(in_data));
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", 64'(out_data.field_value), 64'd0);
        end else begin
          want = expected_results.pop_front();
          if (out_data.field_value !== want.field_value)
            report_mismatch("field_value", 64'(out_data.field_value),
                            64'(want.field_value));
          if (out_data.normal_x !== want.normal_x)
            report_mismatch("normal_x", 64'(out_data.normal_x), 64'(want.normal_x));
          if (out_data.normal_y !== want.normal_y)
            report_mismatch("normal_y", 64'(out_data.normal_y), 64'(want.normal_y));
          if (out_data.normal_z !== want.normal_z)
            report_mismatch("normal_z", 64'(out_data.normal_z), 64'(want.normal_z));
          if (out_data.status !== want.status)
            report_mismatch("status", 64'(out_data.status), 64'(want.status));
          if (out_data.stored_balls !== want.stored_balls)
            report_mismatch("stored_balls", 64'(out_data.stored_balls),
                            64'(want.stored_balls));
        end
      end
      if (cycle_count > CYCLE_LIMIT) begin
        $display("metaball_field_evaluator_top: mismatch");
        $finish;
      end
    end
  end

  // stimulus and end of run
  initial begin
    int n;
    int r;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    in_idle = 0;
    out_idle = 0;
    idling_on = 1'b1;
    mismatch_count = 0;
    cycle_count = 0;
    tbl_count = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: empty table, extremes, zero distance, full table, unused code
    pending_items.push_back(make_item(ACT_EVAL, 0, 0, 0, 0));
    pending_items.push_back(make_item(ACT_NONE, 32'hFFFF, 32'hFFFF, 32'hFFFF, 32'hFFFF));
    pending_items.push_back(make_item(ACT_ADD, 0, 0, 0, 32'hFFFF));
    pending_items.push_back(make_item(ACT_EVAL, 0, 0, 0, 0));
    pending_items.push_back(make_item(ACT_EVAL, 32'h7FFF, 32'h8000, 32'h7FFF, 32'hFFFF));
    pending_items.push_back(make_item(ACT_ADD, 32'h8000, 32'h7FFF, 32'h8000, 0));
    pending_items.push_back(make_item(ACT_EVAL, 32'h7FFF, 32'h8000, 32'h7FFF, 0));
    pending_items.push_back(make_item(ACT_EVAL, 1, 0, 32'hFFFF, 0));
    for (int i = 2; i < NBALLS; i++)
      pending_items.push_back(make_item(ACT_ADD, i * 64, -i * 32, i, 256 + i));
    pending_items.push_back(make_item(ACT_ADD, 5, 5, 5, 5));
    pending_items.push_back(make_item(ACT_EVAL, 100, -100, 50, 0));
    pending_items.push_back(make_item(ACT_CLEAR, 32'hFFFF, 0, 32'hFFFF, 32'hFFFF));
    pending_items.push_back(make_item(ACT_EVAL, 3, 3, 3, 3));

    // random: mostly small tables built then probed
    n = 0;
    while (n < 1000) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        pending_items.push_back(make_item(ACT_CLEAR, $urandom, $urandom, $urandom, $urandom));
      end else if (r < 40) begin
        pending_items.push_back(make_item(ACT_ADD, rand_coord(), rand_coord(), rand_coord(),
                                          $urandom_range(0, 65535)));
      end else if (r < 97) begin
        pending_items.push_back(make_item(ACT_EVAL, rand_coord(), rand_coord(), rand_coord(),
                                          $urandom));
      end else begin
        pending_items.push_back(make_item(ACT_NONE, $urandom, $urandom, $urandom, $urandom));
      end
      n++;
      // keep tables small most of the time so evaluations stay short
      if ($urandom_range(0, 19) == 0)
        pending_items.push_back(make_item(ACT_CLEAR, 0, 0, 0, 0));
      if (n == 900) begin
        while (pending_items.size() != 0) @(posedge clk);
        idling_on = 1'b0;
      end
    end

    while (pending_items.size() != 0 || in_valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("metaball_field_evaluator_top: match");
    end else begin
      $display("metaball_field_evaluator_top: mismatch");
    end
    $finish;
  end

endmodule

// File: metaball_field_evaluator_top.f
rtl/mfe_pkg.sv
rtl/mfe_ram.sv
rtl/metaball_field_evaluator_top.sv
test/tb_metaball_field_evaluator_top.sv
